[design/sapm_pkg.sv]
`default_nettype none
package sapm_pkg;

    // window average is taken by a shift, so WINDOW_LEN stays a power of two
    localparam int WINDOW_LEN = 8;
    localparam int SAMPLE_W   = 10;
    localparam int PCT_W      = 7;
    localparam int PCT_SCALE  = 100;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int LEN_BITS = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0;
    localparam int SUM_W    = SAMPLE_W + LEN_BITS;
    localparam int PROD_W   = SAMPLE_W + PCT_W;
    localparam int DIV_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int LEN_W    = $clog2(WINDOW_LEN + 1);
    localparam int DEN_W    = (SAMPLE_W > LEN_W) ? SAMPLE_W : LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(SAMPLE_MAX * WINDOW_LEN);

    typedef enum logic [1:0] {
        REG_DRY    = 2'd0,
        REG_WET    = 2'd1,
        REG_MARGIN = 2'd2
    } sapm_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_UPDATE,
        ST_AVG,
        ST_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } sapm_state_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } sapm_div_req_t;

endpackage
`default_nettype wire

[design/sapm_ram.sv]
`default_nettype none
module sapm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/sapm_div.sv]
`default_nettype none
module sapm_div (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire sapm_pkg::sapm_div_req_t req,
    output logic                        done,
    output logic [sapm_pkg::DIV_W-1:0]  quot
);
    import sapm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]       trial;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

[design/sensor_average_percent_map.sv]
`default_nettype none
// Moving average of 10-bit converter samples over a ring of WINDOW_LEN words
// held in a small RAM, followed by a linear map from the dry point (0 %) to
// the wet point (100 %), truncated toward zero and clamped to 0..100, plus a
// flag telling whether the average lies within the margin of the span.
// Each item passes the states UPDATE (or FILL), AVG, MUL, PCT_GO, PCT_WAIT
// and OUT, and OUT waits while the output is stalled: the window sum is
// divided by a shift, and the scaled calibration offset passes through a
// divider that retires one quotient bit per cycle. Equal calibration
// points give 0 % and skip the divider. The first sample after reset is
// written to every window entry. A new word is taken only in the idle
// state, once the last result is in the output register, so it can be
// taken while a finished result still waits on the output register.
// Register writes (cfg_we, cfg_index, cfg_wdata) apply from the next sample
// only if the user makes them while no sample is in flight; the block does not enforce this.
module sensor_average_percent_map (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [sapm_pkg::SAMPLE_W-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sapm_pkg::SAMPLE_W-1:0] s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [sapm_pkg::SAMPLE_W-1:0] m_average,
    output logic      [sapm_pkg::PCT_W-1:0]    m_percent,
    output logic                               m_in_range
);
    import sapm_pkg::*;

    sapm_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] dry_reg, wet_reg, margin_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                primed_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic                range_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] dmag_reg;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_average_reg;
    logic [PCT_W-1:0]    m_percent_reg;
    logic                m_in_range_reg;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic                div_start;
    sapm_div_req_t       div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    logic                accept;
    logic                out_load;
    logic signed [SAMPLE_W:0]   diff_s, den_s;
    logic [SAMPLE_W-1:0]        diff_mag, den_mag;
    logic [SAMPLE_W-1:0]        span_lo, span_hi;
    logic signed [SAMPLE_W+1:0] lo_s, hi_s, avg_s;
    logic                       range_now;
    logic [PCT_W-1:0]           pct_now;

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_reg    <= SAMPLE_W'(800);
            wet_reg    <= SAMPLE_W'(400);
            margin_reg <= SAMPLE_W'(50);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DRY:    dry_reg    <= cfg_wdata;
                REG_WET:    wet_reg    <= cfg_wdata;
                REG_MARGIN: margin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sapm_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(WINDOW_LEN)
    ) u_window (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(sample_reg),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    sapm_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .req    (div_req),
        .done   (div_done),
        .quot   (div_quot)
    );

    // calibration math on the registered average
    always_comb begin
        diff_s   = $signed({1'b0, avg_reg}) - $signed({1'b0, dry_reg});
        den_s    = $signed({1'b0, wet_reg}) - $signed({1'b0, dry_reg});
        diff_mag = diff_s[SAMPLE_W] ? SAMPLE_W'(-diff_s) : diff_s[SAMPLE_W-1:0];
        den_mag  = den_s[SAMPLE_W]  ? SAMPLE_W'(-den_s)  : den_s[SAMPLE_W-1:0];
        span_lo  = (wet_reg < dry_reg) ? wet_reg : dry_reg;
        span_hi  = (wet_reg > dry_reg) ? wet_reg : dry_reg;
        lo_s     = $signed({2'b00, span_lo}) - $signed({2'b00, margin_reg});
        hi_s     = $signed({2'b00, span_hi}) + $signed({2'b00, margin_reg});
        avg_s    = $signed({2'b00, avg_reg});
        range_now = (avg_s >= lo_s) && (avg_s <= hi_s);
        if (neg_reg) begin
            pct_now = '0;
        end else if (div_quot >= DIV_W'(PCT_SCALE)) begin
            pct_now = PCT_W'(PCT_SCALE);
        end else begin
            pct_now = div_quot[PCT_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = slot_reg;
        div_start  = 1'b0;
        div_req.num = DIV_W'(prod_reg);
        div_req.den = DEN_W'(dmag_reg);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = primed_reg ? ST_UPDATE : ST_FILL;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                if (fill_reg == SLOT_W'(WINDOW_LEN - 1)) begin
                    state_next = ST_AVG;
                end
            end
            ST_UPDATE: begin
                ram_we     = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = (den_s == '0) ? ST_OUT : ST_PCT_GO;
            end
            ST_PCT_GO: begin
                div_start  = 1'b1;
                state_next = ST_PCT_WAIT;
            end
            ST_PCT_WAIT: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
            primed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: fill_reg <= '0;
                ST_FILL: begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg == SLOT_W'(WINDOW_LEN - 1)) begin
                        sum_reg    <= SUM_W'(sample_reg) * SUM_W'(WINDOW_LEN);
                        primed_reg <= 1'b1;
                    end
                end
                ST_UPDATE: begin
                    // ram_rdata is the oldest entry, read at accept
                    sum_reg  <= sum_reg - SUM_W'(ram_rdata) + SUM_W'(sample_reg);
                    slot_reg <= (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                                      : slot_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        if (state_reg == ST_AVG) begin
            avg_reg <= sum_reg[SUM_W-1:LEN_BITS];
        end
        if (state_reg == ST_MUL) begin
            prod_reg  <= PROD_W'(diff_mag) * PROD_W'(PCT_SCALE);
            dmag_reg  <= den_mag;
            neg_reg   <= (diff_s[SAMPLE_W] != den_s[SAMPLE_W]) && (diff_s != '0);
            range_reg <= range_now;
            pct_reg   <= '0;
        end
        if (state_reg == ST_PCT_WAIT && div_done) begin
            pct_reg <= pct_now;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg  <= avg_reg;
            m_percent_reg  <= pct_reg;
            m_in_range_reg <= range_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_average  = m_average_reg;
    assign m_percent  = m_percent_reg;
    assign m_in_range = m_in_range_reg;

`ifndef NO_ASSERTIONS
    a_primed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_FILL || state_reg == ST_UPDATE))
        else $error("accepted word not dispatched");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_MAX)
        else $error("window sum out of range");

    a_out_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result loaded outside output state");

    a_pct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_percent_reg <= PCT_W'(PCT_SCALE))
        else $error("percent above scale");
`endif

endmodule
`default_nettype wire

[test/tb_sensor_average_percent_map.sv]
`default_nettype none
module tb_sensor_average_percent_map;
    import sapm_pkg::*;

    // writes to this index must be ignored by the block
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int GAP_MAX = 14;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [PCT_W-1:0]    percent;
        logic                in_range;
    } reading_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_average;
    logic [PCT_W-1:0] m_percent;
    logic m_in_range;

    sensor_average_percent_map dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average),
        .m_percent (m_percent),
        .m_in_range(m_in_range)
    );

    // predictor state
    logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
    int win_slot = 0;
    int win_sum = 0;
    bit win_primed = 1'b0;
    int cal_dry = 800;
    int cal_wet = 400;
    int cal_margin = 50;

    logic [SAMPLE_W-1:0] sample_backlog [$];
    reading_t expected_readings [$];
    int errors = 0;
    int tx_hold = 0;
    int rx_hold = 0;
    int rx_draw;
    bit steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1500000;
        $display("sensor_average_percent_map verification failed");
        $finish;
    end

    function automatic reading_t predict_moisture(input logic [SAMPLE_W-1:0] smp);
        reading_t r;
        int avg, den, pct, lo, hi;
        if (!win_primed) begin
            foreach (win_mem[i]) win_mem[i] = smp;
            win_sum = int'(smp) * WINDOW_LEN;
            win_slot = 0;
            win_primed = 1'b1;
        end else begin
            win_sum = win_sum - int'(win_mem[win_slot]) + int'(smp);
            win_mem[win_slot] = smp;
            win_slot = (win_slot + 1) % WINDOW_LEN;
        end
        avg = win_sum / WINDOW_LEN;
        den = cal_wet - cal_dry;
        if (den == 0) begin
            pct = 0;
        end else begin
            pct = ((avg - cal_dry) * PCT_SCALE) / den;
            if (pct < 0) pct = 0;
            if (pct > PCT_SCALE) pct = PCT_SCALE;
        end
        lo = (cal_wet < cal_dry ? cal_wet : cal_dry) - cal_margin;
        hi = (cal_wet > cal_dry ? cal_wet : cal_dry) + cal_margin;
        r.average = SAMPLE_W'(avg);
        r.percent = PCT_W'(pct);
        r.in_range = (avg >= lo && avg <= hi);
        return r;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return SAMPLE_W'(SAMPLE_MAX);
            2: return SAMPLE_W'($urandom_range(1, 8));
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // half the readings lie around the calibration span (margin plus 16 either side), the rest at the rails or anywhere
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int lo, hi;
        lo = (cal_dry < cal_wet ? cal_dry : cal_wet) - cal_margin - 16;
        hi = (cal_dry > cal_wet ? cal_dry : cal_wet) + cal_margin + 16;
        if (lo < 0) lo = 0;
        if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SAMPLE_W'(SAMPLE_MAX);
            2, 3, 4: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            default: return SAMPLE_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [SAMPLE_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DRY:    cal_dry = int'(val);
            REG_WET:    cal_wet = int'(val);
            REG_MARGIN: cal_margin = int'(val);
            default: ;
        endcase
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (sample_backlog.size() != 0 || s_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void note_mismatch(input string what);
        errors++;
        if (errors <= 10) $display("%s", what);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_hold <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_readings.push_back(predict_moisture(s_sample));
            if (tx_hold != 0) begin
                s_valid <= 1'b0;
                tx_hold <= tx_hold - 1;
            end else if (sample_backlog.size() != 0) begin
                s_valid <= 1'b1;
                s_sample <= sample_backlog.pop_front();
                tx_hold <= draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                note_mismatch($sformatf("unexpected word: average %0d percent %0d in_range %0b",
                                        m_average, m_percent, m_in_range));
            end else begin
                reading_t want;
                want = expected_readings.pop_front();
                if (m_average !== want.average || m_percent !== want.percent ||
                    m_in_range !== want.in_range)
                    note_mismatch($sformatf(
                        "mismatch: average exp %0d got %0d, percent exp %0d got %0d, %s",
                        want.average, m_average, want.percent, m_percent,
                        $sformatf("in_range exp %0b got %0b", want.in_range, m_in_range)));
            end
            rx_draw = draw_gap();
            if (rx_draw == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold <= rx_draw - 1;
            end
        end else if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int kind;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset calibration (wet below dry); first word fills the window
        sample_backlog.push_back(SAMPLE_W'(SAMPLE_MAX));
        repeat (8) sample_backlog.push_back('0);
        sample_backlog.push_back(10'd400);
        sample_backlog.push_back(10'd800);
        sample_backlog.push_back(10'd600);
        settle();

        // equal calibration points, zero margin
        write_reg(REG_DRY, 10'd512);
        write_reg(REG_WET, 10'd512);
        write_reg(REG_MARGIN, 10'd0);
        sample_backlog.push_back(10'd512);
        sample_backlog.push_back(10'd0);
        sample_backlog.push_back(SAMPLE_W'(SAMPLE_MAX));
        sample_backlog.push_back(10'd511);
        sample_backlog.push_back(10'd513);
        settle();

        // full span, widest margin, and a write to the unused index
        steady = 1'b1;
        write_reg(REG_DRY, 10'd0);
        write_reg(REG_WET, SAMPLE_W'(SAMPLE_MAX));
        write_reg(REG_MARGIN, SAMPLE_W'(SAMPLE_MAX));
        write_reg(REG_SPARE, 10'h2aa);
        repeat (4) sample_backlog.push_back(SAMPLE_W'(SAMPLE_MAX));
        repeat (4) sample_backlog.push_back('0);
        settle();

        for (int phase = 0; phase < 12; phase++) begin
            kind = $urandom_range(0, 3);
            write_reg(REG_DRY, pick_level());
            write_reg(REG_WET, (kind == 0) ? SAMPLE_W'(cal_dry) : pick_level());
            write_reg(REG_MARGIN, pick_level());
            if (kind == 1) write_reg(REG_SPARE, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
            steady = ($urandom_range(0, 3) == 0);
            repeat (108) sample_backlog.push_back(pick_sample());
            settle();
        end

        if (errors == 0 && expected_readings.size() == 0)
            $display("sensor_average_percent_map verification clean");
        else
            $display("sensor_average_percent_map verification failed");
        $finish;
    end
endmodule
`default_nettype wire
